// ----- rtl/core/http_chunked_stream_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the chunked stream decoder RTL
// Each macro places one labelled concurrent assertion on the rising clock
// edge, disabled while the synchronous reset is high.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_STREAM_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_STREAM_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HCSD_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hcsd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define HCSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hcsd assertion failed");

`endif

// ----- rtl/core/hcsd_pkg.sv -----
// ----------------------------------------------------------------------------
// hcsd_pkg
// Shared types and character constants of the chunked stream decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcsd_pkg;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;

  // A received byte together with its classification, as queued between
  // the front and back parts.
  typedef struct packed {
    logic [7:0] data;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_cr;
    logic       is_lf;
    logic       is_semi;
  } class_t;

endpackage

// ----- rtl/core/hcsd_front.sv -----
// ----------------------------------------------------------------------------
// hcsd_front
// Accepts input bytes and classifies each one ahead of the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcsd_front import hcsd_pkg::*; (
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  output logic       push,
  output class_t     push_item,
  input  logic       q_full
);

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_item         = '0;
    push_item.data    = data_byte;
    push_item.is_cr   = (data_byte == CHAR_CR);
    push_item.is_lf   = (data_byte == CHAR_LF);
    push_item.is_semi = (data_byte == CHAR_SEMI);
    if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
      push_item.is_hex  = 1'b1;
      push_item.hex_val = data_byte[3:0];
    end else if ((data_byte >= 8'h61 && data_byte <= 8'h66) ||
                 (data_byte >= 8'h41 && data_byte <= 8'h46)) begin
      // Letters a to f and A to F share their low four bits: value is 9 + low bits.
      push_item.is_hex  = 1'b1;
      push_item.hex_val = 4'd9 + data_byte[3:0];
    end
  end

endmodule

// ----- rtl/core/hcsd_queue.sv -----
// ----------------------------------------------------------------------------
// hcsd_queue
// Two-entry queue of classified bytes between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcsd_queue import hcsd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  class_t push_item,
  output logic   full,
  input  logic   pop,
  output logic   q_valid,
  output class_t head
);

  class_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- rtl/core/hcsd_back.sv -----
// ----------------------------------------------------------------------------
// hcsd_back
// Chunk framing parser: consumes classified bytes and drives the result
// register, or passes bytes straight through when chunked mode is off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "http_chunked_stream_decoder_assert.svh"

module hcsd_back import hcsd_pkg::*; #(
  parameter int SIZE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       q_valid,
  input  class_t     head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       payload_valid,
  output logic [7:0] payload_byte,
  output logic       chunk_done,
  output logic       final_chunk,
  output logic       format_error
);

  typedef enum logic [2:0] {
    PH_SIZE = 3'd0,
    PH_LF   = 3'd1,
    PH_DATA = 3'd2,
    PH_EXT  = 3'd3,
    PH_DCR  = 3'd4,
    PH_DLF  = 3'd5
  } phase_t;

  phase_t                 phase, phase_next;
  logic [SIZE_BITS-1:0]   remaining, remaining_next;
  logic                   chunked_enable;
  logic                   pv, dn, fn, er;
  logic [7:0]             pb;

  assign pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    pv = 1'b0;
    pb = 8'd0;
    dn = 1'b0;
    fn = 1'b0;
    er = 1'b0;
    if (!chunked_enable) begin
      pv = 1'b1;
      pb = head.data;
    end else begin
      unique case (phase)
        PH_SIZE: begin
          if (head.is_hex) begin
            if (remaining[SIZE_BITS-1 -: 4] != 4'd0) begin
              er = 1'b1;
            end else begin
              remaining_next = {remaining[SIZE_BITS-5:0], head.hex_val};
            end
          end else if (head.is_cr) begin
            phase_next = PH_LF;
          end else if (head.is_semi) begin
            phase_next = PH_EXT;
          end else begin
            er = 1'b1;
          end
        end
        PH_EXT: begin
          if (head.is_cr) begin
            phase_next = PH_LF;
          end
        end
        PH_LF: begin
          if (head.is_lf) begin
            if (remaining != '0) begin
              phase_next = PH_DATA;
            end else begin
              fn         = 1'b1;
              phase_next = PH_SIZE;
            end
          end else begin
            er = 1'b1;
          end
        end
        PH_DATA: begin
          if (remaining != '0) begin
            pv             = 1'b1;
            pb             = head.data;
            remaining_next = remaining - SIZE_BITS'(1);
            if (remaining == SIZE_BITS'(1)) begin
              dn         = 1'b1;
              phase_next = PH_DCR;
            end
          end else if (head.is_cr) begin
            phase_next = PH_DLF;
          end else begin
            phase_next = PH_DCR;
            er         = 1'b1;
          end
        end
        PH_DCR: begin
          if (head.is_cr) begin
            phase_next = PH_DLF;
          end else begin
            er = 1'b1;
          end
        end
        PH_DLF: begin
          if (head.is_lf) begin
            phase_next     = PH_SIZE;
            remaining_next = '0;
          end else begin
            er = 1'b1;
          end
        end
        default: begin
          phase_next     = PH_SIZE;
          remaining_next = '0;
          er             = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunked_enable <= 1'b0;
      phase          <= PH_SIZE;
      remaining      <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        chunked_enable <= cfg_wr_data;
      end
      if (pop) begin
        phase     <= phase_next;
        remaining <= remaining_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload is loaded on every transfer out of the queue.
  always_ff @(posedge clk) begin
    if (pop) begin
      payload_valid <= pv;
      payload_byte  <= pb;
      chunk_done    <= dn;
      final_chunk   <= fn;
      format_error  <= er;
    end
  end

  `HCSD_ASSERT_SAME(a_err_no_payload, clk, rst, out_valid && format_error, !payload_valid)
  `HCSD_ASSERT_SAME(a_done_has_payload, clk, rst, out_valid && chunk_done, payload_valid)
  `HCSD_ASSERT_SAME(a_final_no_payload, clk, rst, out_valid && final_chunk, !payload_valid)
  `HCSD_ASSERT_NEXT(a_done_to_dcr, clk, rst, pop && dn, phase == PH_DCR && remaining == '0)

endmodule

// ----- rtl/core/http_chunked_stream_decoder.sv -----
// An accepted byte is queued, then registered as a result when the output can take it.
// Throughput: one byte per cycle while the output is not stalled, set by the back-part parser.
// A two-entry queue and the output register let either side stall on its own.
// Reset (rst, synchronous, active high) clears the queue, the output valid flag,
// the parser phase, the size count and chunked mode; no clearing pass is needed.
// ----------------------------------------------------------------------------
// http_chunked_stream_decoder
// Decodes HTTP chunked transfer framing from a byte stream, or passes bytes
// straight through when chunked mode is off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module http_chunked_stream_decoder import hcsd_pkg::*; #(
  parameter int SIZE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       payload_valid,
  output logic [7:0] payload_byte,
  output logic       chunk_done,
  output logic       final_chunk,
  output logic       format_error
);

  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_valid;
  class_t push_item;
  class_t head;

  hcsd_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  hcsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  hcsd_back #(
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .q_valid       (q_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .payload_valid (payload_valid),
    .payload_byte  (payload_byte),
    .chunk_done    (chunk_done),
    .final_chunk   (final_chunk),
    .format_error  (format_error)
  );

endmodule
